// ===== rtl/core/skt_pkg.sv =====
// ============================================================================
// skt_pkg - shared types and constants for the sorted key table
// Transaction structs, operation and status codes, sequencer states.
// ============================================================================
package skt_pkg;

    localparam int KEY_W = 31;
    localparam int PAY_W = 64;
    localparam int POS_W = 7;
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_e_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_BEYOND    = 2'd3
    } status_e_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_FIRST,
        ST_INS_SCAN_RD,
        ST_INS_SCAN_CMP,
        ST_INS_SHIFT_RD,
        ST_INS_SHIFT_WR,
        ST_REM_SCAN_RD,
        ST_REM_SCAN_CMP,
        ST_REM_SHIFT_RD,
        ST_REM_SHIFT_WR,
        ST_RD_WAIT,
        ST_DONE
    } state_e_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [POS_W-1:0] position;
    } req_item_t;

    typedef struct packed {
        status_e_t        status;
        logic [KEY_W-1:0] key_out;
        logic [PAY_W-1:0] payload_out;
        logic [CNT_W-1:0] count;
        logic             empty_res;
    } rsp_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

endpackage

// ===== rtl/core/skt_mem.sv =====
// ============================================================================
// skt_mem - entry storage
// One write port and one read port with registered read data.
// ============================================================================
module skt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic [AW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  skt_pkg::entry_t wr_entry,
    output skt_pkg::entry_t rd_entry
);
    import skt_pkg::*;

    entry_t entry_mem [DEPTH];
    entry_t rd_entry_reg;

    // write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
    end

    // register the read data
    always_ff @(posedge clk)
    begin
        rd_entry_reg <= entry_mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== rtl/core/skt_seq.sv =====
// ============================================================================
// skt_seq - operation sequencer
// Scans and shifts the table one entry at a time through a single key
// comparator and the memory's single read port and single write port.
// ============================================================================
module skt_seq #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  skt_pkg::req_item_t req_data,
    output logic               res_valid,
    input  logic               res_take,
    output skt_pkg::rsp_item_t res_data,
    output logic [AW-1:0]      rd_addr,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output skt_pkg::entry_t    wr_entry,
    input  skt_pkg::entry_t    rd_entry
);
    import skt_pkg::*;

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_e_t         state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    op_e_t            op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    j_reg, j_next;
    status_e_t        status_reg, status_next;
    logic [KEY_W-1:0] res_key_reg, res_key_next;
    logic [PAY_W-1:0] res_pay_reg, res_pay_next;

    logic             rd_lt;
    logic             rd_eq;
    logic [CW-1:0]    j_m1;
    logic [CW-1:0]    j_p1;
    logic [CMPW-1:0]  count_ext;
    logic [CMPW-1:0]  pos_eff;
    logic [CMPW-1:0]  pos_m1;

    // shared key comparator: stored key against the operand key
    assign rd_lt = rd_entry.key < key_reg;
    assign rd_eq = rd_entry.key == key_reg;

    assign j_m1      = j_reg - CW'(1);
    assign j_p1      = j_reg + CW'(1);
    assign count_ext = CMPW'(count_reg);
    assign pos_eff   = (pos_reg == '0) ? CMPW'(1) : CMPW'(pos_reg);
    assign pos_m1    = pos_eff - CMPW'(1);

    assign req_stall = state_reg != ST_IDLE;

    // offer the result while in the final state
    assign res_valid = state_reg == ST_DONE;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // operand and work registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        status_reg  <= status_next;
        res_key_reg <= res_key_next;
        res_pay_reg <= res_pay_next;
    end

    // next state and memory control
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        status_next  = status_reg;
        res_key_next = res_key_reg;
        res_pay_next = res_pay_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_entry     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // capture the transaction
                if (req_valid)
                begin
                    op_next    = op_e_t'(req_data.op);
                    key_next   = req_data.key;
                    pay_next   = req_data.payload;
                    pos_next   = req_data.position;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                res_key_next = '0;
                res_pay_next = '0;
                status_next  = STS_OK;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg >= CAP_C)
                        begin
                            status_next = STS_FULL;
                            state_next  = ST_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            idx_next   = '0;
                            j_next     = count_reg;
                            state_next = ST_INS_SHIFT_RD;
                        end
                        else
                        begin
                            rd_addr    = '0;
                            state_next = ST_INS_FIRST;
                        end
                    end
                    OP_REMOVE:
                    begin
                        idx_next   = '0;
                        state_next = ST_REM_SCAN_RD;
                    end
                    OP_READ:
                    begin
                        if (pos_eff > count_ext)
                        begin
                            status_next = STS_BEYOND;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            rd_addr    = pos_m1[AW-1:0];
                            state_next = ST_RD_WAIT;
                        end
                    end
                    OP_NOP:
                    begin
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_INS_FIRST:
            begin
                // a key below the first entry goes in front, else scan from one
                if (!rd_lt && !rd_eq)
                begin
                    idx_next   = '0;
                    j_next     = count_reg;
                    state_next = ST_INS_SHIFT_RD;
                end
                else
                begin
                    idx_next   = CW'(1);
                    state_next = ST_INS_SCAN_RD;
                end
            end
            ST_INS_SCAN_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = ST_INS_SCAN_CMP;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = ST_INS_SHIFT_RD;
                end
            end
            ST_INS_SCAN_CMP:
            begin
                if (rd_lt)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_INS_SCAN_RD;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = ST_INS_SHIFT_RD;
                end
            end
            ST_INS_SHIFT_RD:
            begin
                // move entries up one place, then drop the new entry in the gap
                if (j_reg > idx_reg)
                begin
                    rd_addr    = j_m1[AW-1:0];
                    state_next = ST_INS_SHIFT_WR;
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = idx_reg[AW-1:0];
                    wr_entry.key     = key_reg;
                    wr_entry.payload = pay_reg;
                    count_next       = count_reg + CW'(1);
                    state_next       = ST_DONE;
                end
            end
            ST_INS_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_entry   = rd_entry;
                j_next     = j_m1;
                state_next = ST_INS_SHIFT_RD;
            end
            ST_REM_SCAN_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = ST_REM_SCAN_CMP;
                end
                else
                begin
                    status_next = STS_NOT_FOUND;
                    state_next  = ST_DONE;
                end
            end
            ST_REM_SCAN_CMP:
            begin
                if (rd_eq)
                begin
                    j_next     = idx_reg;
                    state_next = ST_REM_SHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_REM_SCAN_RD;
                end
            end
            ST_REM_SHIFT_RD:
            begin
                // close the gap by moving later entries down one place
                if (j_p1 < count_reg)
                begin
                    rd_addr    = j_p1[AW-1:0];
                    state_next = ST_REM_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_REM_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_entry   = rd_entry;
                j_next     = j_p1;
                state_next = ST_REM_SHIFT_RD;
            end
            ST_RD_WAIT:
            begin
                res_key_next = rd_entry.key;
                res_pay_next = rd_entry.payload;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register takes it
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_data.status      = status_reg;
    assign res_data.key_out     = res_key_reg;
    assign res_data.payload_out = res_pay_reg;
    assign res_data.count       = count_ext[CNT_W-1:0];
    assign res_data.empty_res   = count_reg == '0;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1)
             || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |=> $stable(count_reg))
        else $error("entry count changed outside an operation");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(wr_addr) < CAP_C))
        else $error("write address beyond capacity");

endmodule

// ===== rtl/core/sorted_key_table.sv =====
// ============================================================================
// sorted_key_table - bounded table of (key, payload) entries in key order
// Insert, remove by key, read by position and no-op; one result per transaction.
// ============================================================================
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   req     | in        | req_valid/req_stall  | skt_pkg::req_item_t
//   rsp     | out       | rsp_valid/rsp_stall  | skt_pkg::rsp_item_t
//
// Each transaction walks the table one entry at a time through the single
// key comparator and the memory's read and write ports: a read fetches one
// entry, an insert or remove scans for its place and then shifts entries.
// Reset clears count, state and output valid; entry storage is not cleared.
// The result waits in an output register; rsp_stall holds it there and, when it
// is full, the sequencer in its final state; req_stall stays high until taken.
// ============================================================================
module sorted_key_table #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  skt_pkg::req_item_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output skt_pkg::rsp_item_t rsp_data
);
    import skt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic            res_valid;
    logic            res_take;
    rsp_item_t       res_data;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_entry;
    entry_t          rd_entry;

    logic            rsp_valid_reg, rsp_valid_next;
    rsp_item_t       rsp_data_reg, rsp_data_next;

    skt_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry),
        .rd_entry  (rd_entry)
    );

    skt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res_data;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != STS_OK)
            |-> (rsp_data.key_out == '0 && rsp_data.payload_out == '0))
        else $error("entry fields nonzero on a failed transaction");

endmodule

// ===== tb/sorted_key_table_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sorted_key_table_checker - predicts and checks sorted key table results
// Watches both channels. On every accepted request transaction it updates a
// shadow copy of the table and queues the result it should produce; every
// accepted result transaction is compared field by field with the oldest one.
// ============================================================================
module sorted_key_table_checker #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  skt_pkg::req_item_t req_data,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  skt_pkg::rsp_item_t rsp_data,
    output int                 fail_count,
    output int                 pending
);
    import skt_pkg::*;

    // shadow of the table contents, kept in key order
    logic [KEY_W-1:0] shadow_keys     [CAPACITY];
    logic [PAY_W-1:0] shadow_payloads [CAPACITY];
    int               shadow_count = 0;

    // results owed by the block, oldest first
    rsp_item_t        owed_results [$];
    rsp_item_t        oldest_owed;
    int               mismatches = 0;
    int               owed_total = 0;

    assign fail_count = mismatches;
    assign pending    = owed_total;

    // apply one operation to the shadow table and return its result
    function automatic rsp_item_t table_apply(req_item_t r);
        rsp_item_t res;
        int        idx;
        int        pos;
        int        j;
        res        = '0;
        res.status = STS_OK;
        case (op_e_t'(r.op))
            OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    res.status = STS_FULL;
                end
                else
                begin
                    // an equal first key puts the new entry right behind it
                    if (shadow_count == 0 || r.key < shadow_keys[0])
                    begin
                        idx = 0;
                    end
                    else
                    begin
                        idx = 1;
                        while (idx < shadow_count && shadow_keys[idx] < r.key)
                            idx++;
                    end
                    for (j = shadow_count; j > idx; j--)
                    begin
                        shadow_keys[j]     = shadow_keys[j-1];
                        shadow_payloads[j] = shadow_payloads[j-1];
                    end
                    shadow_keys[idx]     = r.key;
                    shadow_payloads[idx] = r.payload;
                    shadow_count++;
                end
            end
            OP_REMOVE:
            begin
                idx = 0;
                while (idx < shadow_count && shadow_keys[idx] != r.key)
                    idx++;
                if (idx >= shadow_count)
                begin
                    res.status = STS_NOT_FOUND;
                end
                else
                begin
                    for (j = idx; j + 1 < shadow_count; j++)
                    begin
                        shadow_keys[j]     = shadow_keys[j+1];
                        shadow_payloads[j] = shadow_payloads[j+1];
                    end
                    shadow_count--;
                end
            end
            OP_READ:
            begin
                // position zero reads the first entry
                pos = (r.position < 1) ? 1 : int'(r.position);
                if (pos > shadow_count)
                begin
                    res.status = STS_BEYOND;
                end
                else
                begin
                    res.key_out     = shadow_keys[pos-1];
                    res.payload_out = shadow_payloads[pos-1];
                end
            end
            default:
            begin
                // unused code: no change, status ok
            end
        endcase
        res.count     = CNT_W'(shadow_count);
        res.empty_res = (shadow_count == 0);
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // check results first, then log new requests: a result never belongs
    // to the request accepted at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            owed_results.delete();
            owed_total = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, rsp_data);
                    mismatches++;
                end
                else
                begin
                    oldest_owed = owed_results.pop_front();
                    check_field("status", 64'(oldest_owed.status), 64'(rsp_data.status));
                    check_field("key_out", 64'(oldest_owed.key_out), 64'(rsp_data.key_out));
                    check_field("payload_out", oldest_owed.payload_out,
                                rsp_data.payload_out);
                    check_field("count", 64'(oldest_owed.count), 64'(rsp_data.count));
                    check_field("empty_res", 64'(oldest_owed.empty_res),
                                64'(rsp_data.empty_res));
                end
            end
            if (req_valid && !req_stall)
                owed_results.push_back(table_apply(req_data));
            owed_total = owed_results.size();
        end
    end

endmodule

// ===== tb/sorted_key_table_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sorted_key_table_tb - stimulus and verdict for the sorted key table
// Directed table operations over an empty table, tie ordering, missing keys and
// positions, then random phases of mixed, fill and drain traffic with
// random gaps and stalls on both channels; the checker does the comparing.
// ============================================================================
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 2 * TABLE_DEPTH + 20;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_data;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp_data;

    int        fail_count;
    int        pending;
    int        random_sent;
    int        phase_idx;
    bit        hold_request = 1'b0;

    sorted_key_table #(
        .CAPACITY (TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    sorted_key_table_checker #(
        .CAPACITY (TABLE_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // end the run if the block hangs
    initial
    begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic req_item_t make_op(op_e_t op, logic [KEY_W-1:0] key,
                                          logic [PAY_W-1:0] payload,
                                          logic [POS_W-1:0] position);
        req_item_t item;
        item.op       = op;
        item.key      = key;
        item.payload  = payload;
        item.position = position;
        return item;
    endfunction

    // mostly a small key pool so that ties and remove hits are common
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 6)
            return KEY_W'($urandom_range(0, 31));
        else if (sel == 7)
            return KEY_W'($urandom);
        else if (sel == 8)
            return '0;
        else
            return '1;
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 4) == 0)
            return POS_W'($urandom_range(0, 127));
        return POS_W'($urandom_range(0, 66));
    endfunction

    // offer one request transaction after a random gap; return at the
    // falling edge after it was taken, valid still high
    task automatic send_op(req_item_t item);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // drop valid and hold off until every owed result has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_mixed(int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 8)
                send_op(make_op(OP_INSERT, pick_key(), pick_payload(), pick_position()));
            else if (sel < 14)
                send_op(make_op(OP_REMOVE, pick_key(), pick_payload(), pick_position()));
            else if (sel < 19)
                send_op(make_op(OP_READ, pick_key(), pick_payload(), pick_position()));
            else
                send_op(make_op(OP_NOP, pick_key(), pick_payload(), pick_position()));
            random_sent++;
        end
    endtask

    // enough inserts to reach full from any starting count
    task automatic send_fill();
        int inserts;
        inserts = 0;
        while (inserts < TABLE_DEPTH + 8)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_op(make_op(OP_READ, pick_key(), pick_payload(), pick_position()));
            end
            else
            begin
                send_op(make_op(OP_INSERT, pick_key(), pick_payload(), pick_position()));
                inserts++;
            end
            random_sent++;
        end
    endtask

    // sweep the small key pool a few times to remove its keys from the table
    task automatic send_drain();
        int k;
        repeat (3)
        begin
            for (k = 0; k < 32; k++)
            begin
                send_op(make_op(OP_REMOVE, KEY_W'(k), pick_payload(), pick_position()));
                random_sent++;
                if ($urandom_range(0, 7) == 0)
                begin
                    send_op(make_op(OP_READ, pick_key(), pick_payload(), pick_position()));
                    random_sent++;
                end
            end
        end
    endtask

    // receiver: random stall before each result, one long hold on request
    initial
    begin
        int hold_cycles;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_cycles  = LONG_HOLD;
            end
            else
            begin
                hold_cycles = $urandom_range(0, 7);
            end
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int p;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        random_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: read, missing key, unused code
        send_op(make_op(OP_READ, '0, '0, 7'd0));
        send_op(make_op(OP_READ, '0, '0, 7'd1));
        send_op(make_op(OP_REMOVE, 31'd5, '0, '0));
        send_op(make_op(OP_NOP, '1, '1, '1));
        // tie ordering: equal first key, smaller first key, extremes
        send_op(make_op(OP_INSERT, 31'd100, '1, '0));
        send_op(make_op(OP_INSERT, 31'd100, 64'd1, '0));
        send_op(make_op(OP_INSERT, 31'd100, 64'd2, '0));
        send_op(make_op(OP_INSERT, 31'd50, 64'd3, '0));
        send_op(make_op(OP_INSERT, 31'd100, 64'd4, '1));
        send_op(make_op(OP_INSERT, '1, '0, '0));
        send_op(make_op(OP_INSERT, '0, 64'hAAAA_AAAA_AAAA_AAAA, '0));
        send_op(make_op(OP_INSERT, '0, 64'h5555_5555_5555_5555, '0));
        // walk every position, zero and one past the end included
        for (p = 0; p <= 9; p++)
            send_op(make_op(OP_READ, '1, '1, POS_W'(p)));
        send_op(make_op(OP_READ, '0, '0, '1));
        send_op(make_op(OP_REMOVE, 31'd100, '0, '0));
        send_op(make_op(OP_REMOVE, '0, '0, '0));
        send_op(make_op(OP_REMOVE, '1, '0, '0));
        send_op(make_op(OP_REMOVE, 31'd12345, '0, '0));
        wait_drained();

        // random phases
        phase_idx = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            // back up the result side while requests keep coming
            if (phase_idx == 2 || phase_idx == 9)
                hold_request = 1'b1;
            case ($urandom_range(0, 3))
                0, 1:    send_mixed(60);
                2:       send_fill();
                default: send_drain();
            endcase
            if (phase_idx == 4 || $urandom_range(0, 3) == 0)
                wait_drained();
            phase_idx++;
        end

        // let the last results drain
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
